// ----- rtl/rmh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared constants and cell control type for the running median block.
// ----------------------------------------------------------------------------
package rmh_pkg;

  localparam int CAPACITY_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  typedef struct packed {
    logic ins;
    logic pop;
  } rmh_op_t;

endpackage

// ----- rtl/rmh_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_cell
// One slot of a sorted chain: keeps its value, takes the key, shifts from the
// previous slot on insert, or takes the next slot's value on pop.
// ----------------------------------------------------------------------------
module rmh_cell #(
  parameter int W       = 16,
  parameter bit DESCEND = 1'b1
) (
  input  logic             clk,
  input  rmh_pkg::rmh_op_t op,
  input  logic             valid,
  input  logic [W-1:0]     key,
  input  logic [W-1:0]     q_prev,
  input  logic             ahead_prev,
  input  logic [W-1:0]     q_next,
  output logic [W-1:0]     q,
  output logic             ahead
);
  import rmh_pkg::*;

  logic [W-1:0] q_r;
  logic [W-1:0] q_nxt;

  always_comb begin
    if (DESCEND) begin
      ahead = valid && ($signed(q_r) > $signed(key));
    end else begin
      ahead = valid && ($signed(q_r) < $signed(key));
    end
  end

  always_comb begin
    priority if (op.ins) begin
      if (ahead) begin
        q_nxt = q_r;
      end else if (ahead_prev) begin
        q_nxt = key;
      end else begin
        q_nxt = q_prev;
      end
    end else if (op.pop) begin
      q_nxt = q_next;
    end else begin
      q_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ----- rtl/rmh_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_chain
// Row of sorted cells acting as one half of the store; the top sits in cell 0.
// ----------------------------------------------------------------------------
module rmh_chain #(
  parameter int W       = 16,
  parameter int DEPTH   = 513,
  parameter bit DESCEND = 1'b1,
  parameter int CW      = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  rmh_pkg::rmh_op_t op,
  input  logic [CW-1:0]    count,
  input  logic [W-1:0]     key,
  output logic [W-1:0]     head
);
  import rmh_pkg::*;

  logic [W-1:0] q     [DEPTH];
  logic         ahead [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] q_prev;
    logic         ahead_prev;
    logic [W-1:0] q_next;

    if (i == 0) begin : g_first
      assign q_prev     = key;
      assign ahead_prev = 1'b1;
    end else begin : g_mid
      assign q_prev     = q[i-1];
      assign ahead_prev = ahead[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign q_next = q[i];
    end else begin : g_body
      assign q_next = q[i+1];
    end

    rmh_cell #(
      .W       (W),
      .DESCEND (DESCEND)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .valid      (CW'(i) < count),
      .key        (key),
      .q_prev     (q_prev),
      .ahead_prev (ahead_prev),
      .q_next     (q_next),
      .q          (q[i]),
      .ahead      (ahead[i])
    );
  end

  assign head = q[0];

endmodule

// ----- rtl/running_median_two_heaps.sv -----
`timescale 1ns / 1ps
// Sequence: a held sample is accepted, then passes the insert, rebalance and result
// states; a sample that the full store drops goes from accept straight to result.
// Only one sample is in flight at a time: the next is accepted once the result beat is
// loaded, and a stalled result beat holds the next one back.
// Reset: rst_n low empties both halves at once by clearing the fill counts.
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median over a lower and an upper half kept as sorted cell chains.
// ----------------------------------------------------------------------------
module running_median_two_heaps #(
  parameter int CAPACITY    = rmh_pkg::CAPACITY_DEF,
  parameter int SAMPLE_BITS = rmh_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W       = $clog2(CAPACITY + 1),
  parameter int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_W       = ((SAMPLE_BITS + CNT_W + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // sample
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // median_x2, sample_count, dropped
);
  import rmh_pkg::*;

  localparam int SB       = SAMPLE_BITS;
  localparam int LO_DEPTH = (CAPACITY + 1) / 2 + 1;
  localparam int UP_DEPTH = ((CAPACITY / 2) > 0 ? (CAPACITY / 2) : 1) + 1;
  localparam int LC_W     = $clog2(LO_DEPTH + 1);
  localparam int UC_W     = $clog2(UP_DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int PAD_W    = OUT_W - (SB + 1 + CNT_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_INS  = 4'b0010,
    ST_BAL  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SB-1:0]       sample_r, sample_nxt;
  logic                drop_r, drop_nxt;
  logic [LC_W-1:0]     lc_r, lc_nxt;
  logic [UC_W-1:0]     uc_r, uc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SB:0]         med_r, med_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                drop_out_r, drop_out_nxt;

  rmh_op_t             lo_op, up_op;
  logic [SB-1:0]       lo_key, up_key;
  logic [SB-1:0]       lo_head, up_head;
  logic [SUM_W-1:0]    lc_ext, uc_ext, total;
  logic                to_lower, move_up, move_down, load_out;
  logic [SB:0]         lo_ext, up_ext;

  assign lc_ext   = SUM_W'(lc_r);
  assign uc_ext   = SUM_W'(uc_r);
  assign total    = lc_ext + uc_ext;
  assign to_lower = (lc_r == '0) || ($signed(sample_r) < $signed(lo_head));
  assign move_up   = lc_ext > (uc_ext + SUM_W'(1));
  assign move_down = uc_ext > lc_ext;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  assign lo_ext = {lo_head[SB-1], lo_head};
  assign up_ext = {up_head[SB-1], up_head};

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    drop_nxt      = drop_r;
    lc_nxt        = lc_r;
    uc_nxt        = uc_r;
    out_valid_nxt = out_valid_r;
    med_nxt       = med_r;
    cnt_nxt       = cnt_r;
    drop_out_nxt  = drop_out_r;
    lo_op         = '0;
    up_op         = '0;
    lo_key        = sample_r;
    up_key        = sample_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata[SB-1:0];
          drop_nxt   = (total >= SUM_W'(CAPACITY));
          state_nxt  = (total >= SUM_W'(CAPACITY)) ? ST_DONE : ST_INS;
        end
      end
      ST_INS: begin
        if (to_lower) begin
          lo_op.ins = 1'b1;
          lc_nxt    = lc_r + LC_W'(1);
        end else begin
          up_op.ins = 1'b1;
          uc_nxt    = uc_r + UC_W'(1);
        end
        state_nxt = ST_BAL;
      end
      ST_BAL: begin
        lo_key = up_head;
        up_key = lo_head;
        if (move_up) begin
          lo_op.pop = 1'b1;
          up_op.ins = 1'b1;
          lc_nxt    = lc_r - LC_W'(1);
          uc_nxt    = uc_r + UC_W'(1);
        end else if (move_down) begin
          up_op.pop = 1'b1;
          lo_op.ins = 1'b1;
          uc_nxt    = uc_r - UC_W'(1);
          lc_nxt    = lc_r + LC_W'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          drop_out_nxt  = drop_r;
          cnt_nxt       = total[CNT_W-1:0];
          if (lc_ext > uc_ext) begin
            med_nxt = {lo_head, 1'b0};
          end else if (lc_r != '0) begin
            med_nxt = lo_ext + up_ext;
          end else begin
            med_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lc_r        <= '0;
      uc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lc_r        <= lc_nxt;
      uc_r        <= uc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    drop_r     <= drop_nxt;
    med_r      <= med_nxt;
    cnt_r      <= cnt_nxt;
    drop_out_r <= drop_out_nxt;
  end

  rmh_chain #(
    .W       (SB),
    .DEPTH   (LO_DEPTH),
    .DESCEND (1'b1)
  ) u_lower (
    .clk   (clk),
    .op    (lo_op),
    .count (lc_r),
    .key   (lo_key),
    .head  (lo_head)
  );

  rmh_chain #(
    .W       (SB),
    .DEPTH   (UP_DEPTH),
    .DESCEND (1'b0)
  ) u_upper (
    .clk   (clk),
    .op    (up_op),
    .count (uc_r),
    .key   (up_key),
    .head  (up_head)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PAD_W'(0), drop_out_r, cnt_r, med_r};

endmodule

// ----- rtl/rmh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_checker
// Port-level checks on the running median block, bound to its top level.
// ----------------------------------------------------------------------------
module rmh_checker #(
  parameter int CAPACITY    = rmh_pkg::CAPACITY_DEF,
  parameter int SAMPLE_BITS = rmh_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W       = $clog2(CAPACITY + 1),
  parameter int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_W       = ((SAMPLE_BITS + CNT_W + 2 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);
  import rmh_pkg::*;

  localparam int CNT_LO = SAMPLE_BITS + 1;
  localparam int DROP_B = SAMPLE_BITS + 1 + CNT_W;

  logic [CNT_W-1:0] cnt;
  assign cnt = out_tdata[CNT_LO +: CNT_W];

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input beat taken while previous sample in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result beat changed");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[DROP_B]) |-> (cnt == CNT_W'(CAPACITY)))
    else $error("drop flagged below capacity");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cnt != '0))
    else $error("result beat with empty store");

  a_no_result_unasked: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result beat without a sample in flight");

endmodule

bind running_median_two_heaps rmh_checker #(
  .CAPACITY    (CAPACITY),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_rmh_checker (.*);
